>>> rtl/cfcs_pkg.sv
// Package with shared types, constants and check word logic for the codeword framer.
`timescale 1ns / 1ps
`default_nettype none

package cfcs_pkg;

    localparam int unsigned DATA_W  = 48;
    localparam int unsigned CHECK_W = 16;
    localparam int unsigned CODE_W  = DATA_W + CHECK_W;
    localparam int unsigned CRC_W   = CHECK_W - 1;

    localparam logic [CHECK_W-1:0] POLY_BITS  = 16'h6815;
    localparam logic [CHECK_W-1:0] CHECK_FLIP = 16'h0002;
    localparam logic [CODE_W-1:0]  SYNC_WORD  = 64'hAAAA_AAAA_AAAA_3B28;

    localparam logic OP_RX   = 1'b0;
    localparam logic OP_TX   = 1'b1;
    localparam logic KIND_RX = 1'b0;
    localparam logic KIND_TX = 1'b1;

    localparam logic [DATA_W-1:0] REQ_NONE = 48'd0;
    localparam logic [DATA_W-1:0] REQ_SYNC = 48'd1;

    typedef struct packed {
        logic              opcode;
        logic              rx_bit;
        logic [DATA_W-1:0] tx_request;
    } req_item_t;

    typedef struct packed {
        logic              kind;
        logic [DATA_W-1:0] rx_data;
        logic [CODE_W-1:0] tx_codeword;
    } rsp_item_t;

    typedef logic [DATA_W-1:0][CRC_W-1:0] crc_cols_t;

    // The CRC is linear in the data, so each data bit contributes a fixed column.
    // The columns are found at elaboration by running the bit-serial register.
    function automatic crc_cols_t crc_cols_build();
        crc_cols_t            cols;
        logic [CHECK_W-1:0]   r;
        logic                 b;
        for (int pos = 0; pos < DATA_W; pos++)
        begin
            r = '0;
            for (int i = DATA_W - 1; i >= 0; i--)
            begin
                b = (i == pos);
                if (b ^ r[CHECK_W-1])
                begin
                    r = r ^ POLY_BITS;
                end
                r = {r[CHECK_W-2:0], 1'b0};
            end
            cols[pos] = r[CHECK_W-1:1];
        end
        return cols;
    endfunction

    localparam crc_cols_t CRC_COLS = crc_cols_build();

    // Check word: 15 CRC bits on top, even parity over data and CRC in bit 0.
    function automatic logic [CHECK_W-1:0] check_word(input logic [DATA_W-1:0] data);
        logic [CRC_W-1:0] crc;
        logic             par;
        crc = '0;
        for (int i = 0; i < DATA_W; i++)
        begin
            if (data[i])
            begin
                crc = crc ^ CRC_COLS[i];
            end
        end
        crc = crc ^ CHECK_FLIP[CHECK_W-1:1];
        par = (^data) ^ (^crc);
        return {crc, par};
    endfunction

endpackage

`default_nettype wire

>>> rtl/codeword_fcs_framer.sv
// Top level of the codeword framer: receive window matching and transmit framing.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+------------------------------
//  req     | in        | req_valid / req_ready   | req_item (opcode, rx_bit, tx_request)
//  rsp     | out       | rsp_valid / rsp_ready   | rsp_item (kind, rx_data, tx_codeword)
//
//  One item is accepted per cycle while req_ready is high; a result passes the stage
//  register and is offered from the output register. The bit window shifts at the input
//  transfer, then one stage register feeds the check word logic, and the result sits in an output register.
//  Reset clears the window and the valid flags; no clearing pass is needed.
//  A stalled result blocks only items that make a result; items with none drain.
`timescale 1ns / 1ps
`default_nettype none

module codeword_fcs_framer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire cfcs_pkg::req_item_t req_item,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output cfcs_pkg::rsp_item_t     rsp_item
);

    logic [cfcs_pkg::CODE_W-1:0] window_reg;
    logic [cfcs_pkg::CODE_W-1:0] window_next;

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic                        s1_op_reg;
    logic [cfcs_pkg::CODE_W-1:0] s1_data_reg;
    logic [cfcs_pkg::CODE_W-1:0] s1_data_next;

    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    cfcs_pkg::rsp_item_t         rsp_item_reg;
    cfcs_pkg::rsp_item_t         rsp_item_next;

    logic                        req_xfer;
    logic                        s1_adv;
    logic                        s1_hit;
    logic [cfcs_pkg::DATA_W-1:0] chk_data;
    logic [cfcs_pkg::CHECK_W-1:0] chk_word;
    logic [cfcs_pkg::DATA_W-1:0] s1_req;

    assign req_xfer = req_valid && req_ready;

    always_comb
    begin
        window_next  = window_reg;
        s1_data_next = s1_data_reg;
        if (req_xfer)
        begin
            if (req_item.opcode == cfcs_pkg::OP_RX)
            begin
                window_next  = {window_reg[cfcs_pkg::CODE_W-2:0], req_item.rx_bit};
                s1_data_next = window_next;
            end
            else
            begin
                s1_data_next = {{cfcs_pkg::CHECK_W{1'b0}}, req_item.tx_request};
            end
        end
    end

    // One check unit serves both paths.
    assign s1_req   = s1_data_reg[cfcs_pkg::DATA_W-1:0];
    assign chk_data = (s1_op_reg == cfcs_pkg::OP_RX) ?
                      s1_data_reg[cfcs_pkg::CODE_W-1:cfcs_pkg::CHECK_W] : s1_req;
    assign chk_word = cfcs_pkg::check_word(chk_data);

    always_comb
    begin
        rsp_item_next = '0;
        if (s1_op_reg == cfcs_pkg::OP_RX)
        begin
            s1_hit                = (chk_word == s1_data_reg[cfcs_pkg::CHECK_W-1:0]);
            rsp_item_next.kind    = cfcs_pkg::KIND_RX;
            rsp_item_next.rx_data = chk_data;
        end
        else
        begin
            s1_hit             = (s1_req != cfcs_pkg::REQ_NONE);
            rsp_item_next.kind = cfcs_pkg::KIND_TX;
            if (s1_req == cfcs_pkg::REQ_SYNC)
            begin
                rsp_item_next.tx_codeword = cfcs_pkg::SYNC_WORD;
            end
            else
            begin
                rsp_item_next.tx_codeword = {s1_req, chk_word};
            end
        end
    end

    // An item with no result leaves the stage even while the output is stalled.
    assign s1_adv    = s1_valid_reg && (!s1_hit || !rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (s1_adv && s1_hit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            s1_op_reg <= req_item.opcode;
        end
        s1_data_reg <= s1_data_next;
        if (s1_adv && s1_hit)
        begin
            rsp_item_reg <= rsp_item_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // A stage item that makes a result and moves on shows up at the output.
    a_hit_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_hit && s1_adv |=> rsp_valid_reg)
        else $error("stage result was lost on its way to the output");

    // The field of the other path is always zero in a result.
    a_unused_field_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> ((rsp_item_reg.kind == cfcs_pkg::KIND_RX) ?
                           (rsp_item_reg.tx_codeword == '0) :
                           (rsp_item_reg.rx_data == '0)))
        else $error("result carries a nonzero field of the other path");

    // An empty stage must always take a new item.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> req_ready)
        else $error("input stalled while the stage was empty");

    // A held stage item keeps its contents.
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_data_reg)
                                    && $stable(s1_op_reg))
        else $error("held stage item changed");

    // A received codeword at the output passes its own check.
    a_rx_codeword_checks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_adv && s1_hit && (s1_op_reg == cfcs_pkg::OP_RX)
        |-> (cfcs_pkg::check_word(s1_data_reg[cfcs_pkg::CODE_W-1:cfcs_pkg::CHECK_W])
             == s1_data_reg[cfcs_pkg::CHECK_W-1:0]))
        else $error("received codeword sent out without a matching check word");

endmodule

`default_nettype wire
